[hdl/stx_etx_frame_receiver_defines.svh]
// Assertion macros for the frame receiver.
// Define NO_ASSERTIONS to compile them out.
`ifndef STX_ETX_FRAME_RECEIVER_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define SEFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sefr assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SEFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sefr assertion failed");
`else
`define SEFR_ASSERT_SAME(label, ante, cons)
`define SEFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/sefr_pkg.sv]
`default_nettype none
package sefr_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_SYNC = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FRAMING = 3'd1,
    ST_CSUM    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_COMMAND = 3'd4,
    ST_DEBUG   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_START_BYTE   = 3'd0,
    CFG_END_BYTE     = 3'd1,
    CFG_SYNC_NORMAL  = 3'd2,
    CFG_SYNC_DEBUG   = 3'd3,
    CFG_DEBUG_OPCODE = 3'd4
  } cfg_idx_t;

  localparam byte_t START_BYTE_RST   = 8'h02;
  localparam byte_t END_BYTE_RST     = 8'h03;
  localparam byte_t SYNC_NORMAL_RST  = 8'h00;
  localparam byte_t SYNC_DEBUG_RST   = 8'h01;
  localparam byte_t DEBUG_OPCODE_RST = 8'h01;

  // Valid command opcodes in a normal frame.
  localparam byte_t OPC_FIRST = 8'h01;
  localparam byte_t OPC_LAST  = 8'h06;

  typedef struct packed {
    byte_t start_byte;
    byte_t end_byte;
    byte_t sync_normal;
    byte_t sync_debug;
    byte_t debug_opcode;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] command;
    logic       debug_on;
  } result_t;

endpackage
`default_nettype wire

[hdl/sefr_cfg_regs.sv]
`default_nettype none
module sefr_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata,
  output sefr_pkg::cfg_t       cfg
);
  import sefr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_BYTE:   cfg_nxt.start_byte   = cfg_wdata;
        CFG_END_BYTE:     cfg_nxt.end_byte     = cfg_wdata;
        CFG_SYNC_NORMAL:  cfg_nxt.sync_normal  = cfg_wdata;
        CFG_SYNC_DEBUG:   cfg_nxt.sync_debug   = cfg_wdata;
        CFG_DEBUG_OPCODE: cfg_nxt.debug_opcode = cfg_wdata;
        default:          cfg_nxt = cfg_r;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte   <= START_BYTE_RST;
      cfg_r.end_byte     <= END_BYTE_RST;
      cfg_r.sync_normal  <= SYNC_NORMAL_RST;
      cfg_r.sync_debug   <= SYNC_DEBUG_RST;
      cfg_r.debug_opcode <= DEBUG_OPCODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[hdl/sefr_frame_fsm.sv]
`default_nettype none
module sefr_frame_fsm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire sefr_pkg::cfg_t  cfg,
  output sefr_pkg::result_t    res
);
  import sefr_pkg::*;

  phase_t phase_r, phase_nxt;
  byte_t  remaining_r, remaining_nxt;
  byte_t  frame_sync_r, frame_sync_nxt;
  byte_t  frame_opcode_r, frame_opcode_nxt;
  logic   opcode_seen_r, opcode_seen_nxt;
  byte_t  running_sum_r, running_sum_nxt;
  logic   sum_matched_r, sum_matched_nxt;
  logic   debug_mode_r, debug_mode_nxt;

  status_t    fin_status;
  logic [2:0] fin_command;
  logic       fin_toggle;

  // Next phase.
  always_comb begin
    case (phase_r)
      PH_SYNC: phase_nxt = PH_LEN;
      PH_LEN:  phase_nxt = (rx_byte == 8'd0) ? PH_WAIT : PH_DATA;
      PH_DATA: phase_nxt = (remaining_r != 8'd1) ? PH_DATA : PH_END;
      PH_END:  phase_nxt = PH_WAIT;
      default: phase_nxt = (rx_byte == cfg.start_byte) ? PH_SYNC : PH_WAIT;
    endcase
  end

  // Verdict for a frame closed by the end byte.
  always_comb begin
    fin_status  = ST_UNKNOWN;
    fin_command = 3'd0;
    fin_toggle  = 1'b0;
    if (!debug_mode_r && !sum_matched_r) begin
      fin_status = ST_CSUM;
    end else if (frame_sync_r == cfg.sync_normal) begin
      if (opcode_seen_r && frame_opcode_r >= OPC_FIRST && frame_opcode_r <= OPC_LAST) begin
        fin_status  = ST_COMMAND;
        fin_command = frame_opcode_r[2:0];
      end
    end else if (frame_sync_r == cfg.sync_debug) begin
      if (opcode_seen_r && frame_opcode_r == cfg.debug_opcode) begin
        fin_status = ST_DEBUG;
        fin_toggle = 1'b1;
      end
    end
  end

  // Frame datapath and per-byte result.
  always_comb begin
    remaining_nxt    = remaining_r;
    frame_sync_nxt   = frame_sync_r;
    frame_opcode_nxt = frame_opcode_r;
    opcode_seen_nxt  = opcode_seen_r;
    running_sum_nxt  = running_sum_r;
    sum_matched_nxt  = sum_matched_r;
    debug_mode_nxt   = debug_mode_r;
    res.status       = ST_OK;
    res.command      = 3'd0;
    case (phase_r)
      PH_SYNC: frame_sync_nxt = rx_byte;
      PH_LEN: begin
        if (rx_byte == 8'd0) begin
          res.status = ST_FRAMING;
        end else begin
          remaining_nxt    = rx_byte;
          running_sum_nxt  = 8'd0;
          opcode_seen_nxt  = 1'b0;
          frame_opcode_nxt = 8'd0;
          sum_matched_nxt  = 1'b0;
        end
      end
      PH_DATA: begin
        if (remaining_r != 8'd1) begin
          running_sum_nxt = running_sum_r + rx_byte;
          if (!opcode_seen_r) begin
            frame_opcode_nxt = rx_byte;
            opcode_seen_nxt  = 1'b1;
          end
          remaining_nxt = remaining_r - 8'd1;
        end else begin
          sum_matched_nxt = (rx_byte == running_sum_r);
        end
      end
      PH_END: begin
        if (rx_byte == cfg.end_byte) begin
          res.status     = fin_status;
          res.command    = fin_command;
          debug_mode_nxt = debug_mode_r ^ fin_toggle;
        end else begin
          res.status = ST_FRAMING;
        end
      end
      default: begin
        if (rx_byte != cfg.start_byte) res.status = ST_FRAMING;
      end
    endcase
    res.debug_on = debug_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT;
      remaining_r    <= 8'd0;
      frame_sync_r   <= 8'd0;
      frame_opcode_r <= 8'd0;
      opcode_seen_r  <= 1'b0;
      running_sum_r  <= 8'd0;
      sum_matched_r  <= 1'b0;
      debug_mode_r   <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      remaining_r    <= remaining_nxt;
      frame_sync_r   <= frame_sync_nxt;
      frame_opcode_r <= frame_opcode_nxt;
      opcode_seen_r  <= opcode_seen_nxt;
      running_sum_r  <= running_sum_nxt;
      sum_matched_r  <= sum_matched_nxt;
      debug_mode_r   <= debug_mode_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/stx_etx_frame_receiver.sv]
`default_nettype none
// Byte-stream frame receiver: start byte, sync byte, length L, L-1 data bytes
// (first is the opcode), checksum byte, end byte. Every accepted byte gives
// one result transaction with a status, a command code and the debug flag.
// One byte per cycle is sustained while out_ready is high: a byte sits in the
// input register, the frame state machine evaluates it and the result lands
// in the output register. The input side keeps taking bytes while a result
// waits, until both registers hold one.
// Configuration registers take effect at once; write them only while idle.
`include "stx_etx_frame_receiver_defines.svh"
module stx_etx_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_command,
  output logic             out_debug_on,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import sefr_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic    s1_valid_r, s1_valid_nxt;
  byte_t   s1_byte_r;
  logic    s1_adv;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  // Advance a byte when the output register is free or being drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  sefr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sefr_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '{status: ST_OK, command: 3'd0, debug_on: 1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_rx_byte;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_command  = out_r.command;
  assign out_debug_on = out_r.debug_on;

  `SEFR_ASSERT_SAME(a_cmd_only_with_command, out_valid_r,
    ((out_r.status == ST_COMMAND) == (out_r.command != 3'd0)))
  `SEFR_ASSERT_NEXT(a_debug_flag_flips, s1_adv && res.status == ST_DEBUG,
    out_r.debug_on != $past(out_r.debug_on))
  `SEFR_ASSERT_NEXT(a_no_byte_lost, s1_valid_r && out_valid_r && !out_ready, s1_valid_r)
  `SEFR_ASSERT_NEXT(a_flag_steady_otherwise, s1_adv && res.status != ST_DEBUG,
    out_r.debug_on == $past(out_r.debug_on))

endmodule
`default_nettype wire
